// ===== hdl/fstm_pkg.sv =====
package fstm_pkg;

  // Input field widths
  localparam int STRESS_BITS      = 24;
  localparam int NORMAL_W         = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_BITS         = 25;

  // Traction path
  localparam int P1_W    = STRESS_BITS + NORMAL_W;  // S_rc * n_c
  localparam int ACC1_W  = P1_W + 2;                // sum of three
  localparam int TRAC_W  = STRESS_BITS + 4;         // holds +-2^(STRESS_BITS+2)
  localparam int P2_W    = TRAC_W + NORMAL_W;       // t_r * n_r, tn * n_r
  localparam int ACC2_W  = P2_W + 2;
  localparam longint TRAC_LIM = 64'sd1 <<< (STRESS_BITS + 2);

  // Shear path
  localparam int MAG_W   = OUT_BITS + 1;            // |s_r| after clamp, up to 2^OUT_BITS
  localparam int TSH_W   = P2_W - NORMAL_FRAC_BITS; // tn * n_r after shift
  localparam int SHA_W   = (TRAC_W > TSH_W) ? TRAC_W : TSH_W;
  localparam int SHB_W   = (SHA_W > MAG_W + 1) ? SHA_W : MAG_W + 1;
  localparam int SH_W    = SHB_W + 1;               // t_r - shifted product
  localparam int CSH_W   = MAG_W + 1;               // clamped shear, signed
  localparam longint SHEAR_LIM = 64'sd1 <<< OUT_BITS;

  // Square root
  localparam int SUM_W   = 2 * MAG_W;               // sum of three squares
  localparam int ROOT_W  = MAG_W;
  localparam int REM_W   = ROOT_W + 3;

  // Latency
  localparam int FRONT_STAGES = 9;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W;

endpackage

// ===== hdl/fstm_isqrt.sv =====
module fstm_isqrt
  import fstm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o
);

  // one root bit per stage, restoring digit recurrence
  logic              vld_q  [ROOT_W];
  logic [SUM_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  logic [SUM_W-1:0]  rad_d  [ROOT_W];
  logic [REM_W-1:0]  rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];

  always_comb begin
    logic [SUM_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rad_p  = radicand_i;
        rem_p  = '0;
        root_p = '0;
      end else begin
        rad_p  = rad_q[k-1];
        rem_p  = rem_q[k-1];
        root_p = root_q[k-1];
      end
      rem_in = {rem_p[REM_W-3:0], rad_p[SUM_W-1 -: 2]};
      trial  = (REM_W'(root_p) << 2) | REM_W'(1);
      rad_d[k] = rad_p << 2;
      if (rem_in >= trial) begin
        rem_d[k]  = rem_in - trial;
        root_d[k] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_in;
        root_d[k] = {root_p[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROOT_W; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < ROOT_W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ROOT_W; k++) begin
      rad_q[k]  <= rad_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

  // a zero radicand gives a zero root
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && radicand_i == '0) |-> ##ROOT_W (valid_o && root_o == '0))
    else $error("isqrt: zero radicand gave non-zero root");

  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ROOT_W-1] |-> (rem_q[ROOT_W-1] <= (REM_W'(root_q[ROOT_W-1]) << 1)))
    else $error("isqrt: remainder out of bound");

  // every beat out traces back to a beat in
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, ROOT_W))
    else $error("isqrt: output beat without input beat");

endmodule

// ===== hdl/fault_shear_traction_magnitude_core.sv =====
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------------------------
// command   start / busy       stress_xx_i .. stress_zz_i, normal_x_i .. _z_i
// result    done_o (strobe)    shear_magnitude_o
//
// A beat is taken every cycle; busy is held low, as the pipeline never fills.
// A beat passes nine arithmetic stages, then the one-bit-per-stage
// square root pipeline.
// Reset clears the valid bits only; data registers run free.
// Results appear for one cycle with done_o; the receiver cannot stall.
module fault_shear_traction_magnitude_core
  import fstm_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [STRESS_BITS-1:0] stress_xx_i,
  input  logic signed [STRESS_BITS-1:0] stress_xy_i,
  input  logic signed [STRESS_BITS-1:0] stress_xz_i,
  input  logic signed [STRESS_BITS-1:0] stress_yx_i,
  input  logic signed [STRESS_BITS-1:0] stress_yy_i,
  input  logic signed [STRESS_BITS-1:0] stress_yz_i,
  input  logic signed [STRESS_BITS-1:0] stress_zx_i,
  input  logic signed [STRESS_BITS-1:0] stress_zy_i,
  input  logic signed [STRESS_BITS-1:0] stress_zz_i,
  input  logic signed [NORMAL_W-1:0]    normal_x_i,
  input  logic signed [NORMAL_W-1:0]    normal_y_i,
  input  logic signed [NORMAL_W-1:0]    normal_z_i,
  output logic                          done_o,
  output logic [OUT_BITS-1:0]           shear_magnitude_o
);

  // Stages:
  //  1  S_rc * n_c products
  //  2  row sums, asr, clamp  -> t_r
  //  3  t_r * n_r products
  //  4  sum, asr, clamp       -> tn
  //  5  tn * n_r products
  //  6  t_r - asr(tn*n_r), clamp to +-2^OUT_BITS
  //  7  magnitude
  //  8  squares
  //  9  sum of squares
  //  then the square root pipeline and output saturation.

  logic signed [STRESS_BITS-1:0] s_in [3][3];
  logic signed [NORMAL_W-1:0]    n_in [3];

  assign s_in[0][0] = stress_xx_i;
  assign s_in[0][1] = stress_xy_i;
  assign s_in[0][2] = stress_xz_i;
  assign s_in[1][0] = stress_yx_i;
  assign s_in[1][1] = stress_yy_i;
  assign s_in[1][2] = stress_yz_i;
  assign s_in[2][0] = stress_zx_i;
  assign s_in[2][1] = stress_zy_i;
  assign s_in[2][2] = stress_zz_i;
  assign n_in[0]    = normal_x_i;
  assign n_in[1]    = normal_y_i;
  assign n_in[2]    = normal_z_i;

  assign busy = 1'b0;

  // valid bits, one per front stage
  logic vld_q [FRONT_STAGES];
  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRONT_STAGES; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k < FRONT_STAGES; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // data registers
  logic signed [P1_W-1:0]     p1_q  [3][3];
  logic signed [NORMAL_W-1:0] n1_q  [3];
  logic signed [TRAC_W-1:0]   t2_q  [3];
  logic signed [NORMAL_W-1:0] n2_q  [3];
  logic signed [P2_W-1:0]     p3_q  [3];
  logic signed [TRAC_W-1:0]   t3_q  [3];
  logic signed [NORMAL_W-1:0] n3_q  [3];
  logic signed [TRAC_W-1:0]   tn4_q;
  logic signed [TRAC_W-1:0]   t4_q  [3];
  logic signed [NORMAL_W-1:0] n4_q  [3];
  logic signed [P2_W-1:0]     p5_q  [3];
  logic signed [TRAC_W-1:0]   t5_q  [3];
  logic signed [CSH_W-1:0]    sh6_q [3];
  logic [MAG_W-1:0]           mag7_q [3];
  logic [SUM_W-1:0]           sq8_q [3];
  logic [SUM_W-1:0]           sum9_q;

  // next-value logic
  logic signed [TRAC_W-1:0] t2_d  [3];
  logic signed [TRAC_W-1:0] tn4_d;
  logic signed [CSH_W-1:0]  sh6_d [3];
  logic [MAG_W-1:0]         mag7_d [3];

  // stage 2: row sums, truncating shift, clamp
  always_comb begin
    logic signed [ACC1_W-1:0] acc;
    logic signed [ACC1_W-1:0] shf;
    for (int r = 0; r < 3; r++) begin
      acc = ACC1_W'(p1_q[r][0]) + ACC1_W'(p1_q[r][1]) + ACC1_W'(p1_q[r][2]);
      shf = acc >>> NORMAL_FRAC_BITS;
      if (shf > $signed(ACC1_W'(TRAC_LIM))) begin
        t2_d[r] = TRAC_W'(TRAC_LIM);
      end else if (shf < -$signed(ACC1_W'(TRAC_LIM))) begin
        t2_d[r] = -TRAC_W'(TRAC_LIM);
      end else begin
        t2_d[r] = TRAC_W'(shf);
      end
    end
  end

  // stage 4: normal component of traction
  always_comb begin
    logic signed [ACC2_W-1:0] acc;
    logic signed [ACC2_W-1:0] shf;
    acc = ACC2_W'(p3_q[0]) + ACC2_W'(p3_q[1]) + ACC2_W'(p3_q[2]);
    shf = acc >>> NORMAL_FRAC_BITS;
    if (shf > $signed(ACC2_W'(TRAC_LIM))) begin
      tn4_d = TRAC_W'(TRAC_LIM);
    end else if (shf < -$signed(ACC2_W'(TRAC_LIM))) begin
      tn4_d = -TRAC_W'(TRAC_LIM);
    end else begin
      tn4_d = TRAC_W'(shf);
    end
  end

  // stage 6: shear component, clamped before squaring
  always_comb begin
    logic signed [P2_W-1:0] shf;
    logic signed [SH_W-1:0] dif;
    for (int r = 0; r < 3; r++) begin
      shf = p5_q[r] >>> NORMAL_FRAC_BITS;
      dif = SH_W'(t5_q[r]) - SH_W'(shf);
      if (dif > $signed(SH_W'(SHEAR_LIM))) begin
        sh6_d[r] = CSH_W'(SHEAR_LIM);
      end else if (dif < -$signed(SH_W'(SHEAR_LIM))) begin
        sh6_d[r] = -CSH_W'(SHEAR_LIM);
      end else begin
        sh6_d[r] = CSH_W'(dif);
      end
    end
  end

  // stage 7: magnitude; +-2^OUT_BITS fits MAG_W unsigned
  always_comb begin
    logic signed [CSH_W-1:0] neg;
    for (int r = 0; r < 3; r++) begin
      neg = -sh6_q[r];
      mag7_d[r] = sh6_q[r][CSH_W-1] ? MAG_W'(neg) : MAG_W'(sh6_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p1_q[r][c] <= P1_W'(s_in[r][c]) * P1_W'(n_in[c]);
      end
      n1_q[r]  <= n_in[r];
      t2_q[r]  <= t2_d[r];
      n2_q[r]  <= n1_q[r];
      p3_q[r]  <= P2_W'(t2_q[r]) * P2_W'(n2_q[r]);
      t3_q[r]  <= t2_q[r];
      n3_q[r]  <= n2_q[r];
      t4_q[r]  <= t3_q[r];
      n4_q[r]  <= n3_q[r];
      p5_q[r]  <= P2_W'(tn4_q) * P2_W'(n4_q[r]);
      t5_q[r]  <= t4_q[r];
      sh6_q[r] <= sh6_d[r];
      mag7_q[r] <= mag7_d[r];
      sq8_q[r] <= SUM_W'(mag7_q[r]) * SUM_W'(mag7_q[r]);
    end
    tn4_q  <= tn4_d;
    sum9_q <= sq8_q[0] + sq8_q[1] + sq8_q[2];
  end

  // square root
  logic              root_vld;
  logic [ROOT_W-1:0] root;

  fstm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_q[FRONT_STAGES-1]),
    .radicand_i (sum9_q),
    .valid_o    (root_vld),
    .root_o     (root)
  );

  // saturate: the root can reach just under sqrt(3) * 2^OUT_BITS
  assign done_o            = root_vld;
  assign shear_magnitude_o = root[ROOT_W-1] ? '1 : root[OUT_BITS-1:0];

  // every accepted beat yields exactly one result
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("core: accepted beat produced no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("core: result without accepted beat");

  // a zero normal gives zero traction and zero shear
  a_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0)
      |-> ##LATENCY (shear_magnitude_o == '0))
    else $error("core: zero normal gave non-zero shear");

endmodule

// ===== sim/fault_shear_traction_magnitude_core_tb.sv =====
`timescale 1ns / 100ps

module fault_shear_traction_magnitude_core_tb;
  import fstm_pkg::*;

  typedef logic signed [STRESS_BITS-1:0] stress_t;
  typedef logic signed [NORMAL_W-1:0]    normal_t;
  typedef logic [OUT_BITS-1:0]           mag_t;

  // One command beat: s[r*3+c] is row r column c, n[0..2] is x, y, z
  typedef struct packed {
    stress_t [8:0] s;
    normal_t [2:0] n;
  } beat_t;

  localparam stress_t S_MAX     = {1'b0, {(STRESS_BITS-1){1'b1}}};
  localparam stress_t S_MIN     = {1'b1, {(STRESS_BITS-1){1'b0}}};
  localparam normal_t N_ONE     = normal_t'(1 << NORMAL_FRAC_BITS);
  localparam normal_t N_DIAG    = 16'sd9459;   // 1/sqrt(3) in Q1.14
  localparam normal_t N_HALF2   = 16'sd11585;  // 1/sqrt(2) in Q1.14
  localparam int      NUM_ITEMS = 1400;
  localparam int      MAX_GAP   = 40;
  localparam int      CYCLE_LIMIT = 200000;

  // Expected magnitudes in acceptance order, plus the arithmetic that forms them
  class shear_scoreboard;
    mag_t        awaited[$];
    int unsigned faults = 0;

    static function longint clip(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // Bitwise floor square root, one result bit per pass
    static function longint unsigned floor_root(longint unsigned v);
      longint unsigned root  = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v    -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    static function mag_t shear_length(beat_t b);
      longint          nv[3];
      longint          tr[3];
      longint          acc;
      longint          tnorm;
      longint          sh;
      longint unsigned mag;
      longint unsigned sum = 0;
      longint unsigned root;
      for (int c = 0; c < 3; c++) nv[c] = longint'($signed(b.n[c]));
      // traction t = S.n, truncated towards minus infinity, then bounded
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) acc += longint'($signed(b.s[r*3+c])) * nv[c];
        tr[r] = clip(acc >>> NORMAL_FRAC_BITS, TRAC_LIM);
      end
      acc = tr[0] * nv[0] + tr[1] * nv[1] + tr[2] * nv[2];
      tnorm = clip(acc >>> NORMAL_FRAC_BITS, TRAC_LIM);
      // shear part, each component bounded before squaring
      for (int r = 0; r < 3; r++) begin
        sh  = clip(tr[r] - ((tnorm * nv[r]) >>> NORMAL_FRAC_BITS), SHEAR_LIM);
        mag = longint'(sh < 0 ? -sh : sh);
        sum += mag * mag;
      end
      root = floor_root(sum);
      if (root > (64'd1 << OUT_BITS) - 1) root = (64'd1 << OUT_BITS) - 1;
      return mag_t'(root);
    endfunction

    function void note_beat(beat_t b);
      awaited.push_back(shear_length(b));
    endfunction

    function void check_magnitude(mag_t got);
      mag_t want;
      if (awaited.size() == 0) begin
        $error("shear_magnitude: no beat pending, got %0d", got);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $error("shear_magnitude: expected %0d, got %0d", want, got);
        faults++;
      end
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  stress_t stress_xx_i, stress_xy_i, stress_xz_i;
  stress_t stress_yx_i, stress_yy_i, stress_yz_i;
  stress_t stress_zx_i, stress_zy_i, stress_zz_i;
  normal_t normal_x_i, normal_y_i, normal_z_i;
  logic    done_o;
  mag_t    shear_magnitude_o;

  shear_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     idle_pct    = 0;

  fault_shear_traction_magnitude_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .stress_xx_i       (stress_xx_i),
    .stress_xy_i       (stress_xy_i),
    .stress_xz_i       (stress_xz_i),
    .stress_yx_i       (stress_yx_i),
    .stress_yy_i       (stress_yy_i),
    .stress_yz_i       (stress_yz_i),
    .stress_zx_i       (stress_zx_i),
    .stress_zy_i       (stress_zy_i),
    .stress_zz_i       (stress_zz_i),
    .normal_x_i        (normal_x_i),
    .normal_y_i        (normal_y_i),
    .normal_z_i        (normal_z_i),
    .done_o            (done_o),
    .shear_magnitude_o (shear_magnitude_o)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop, well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Monitor: values read at the edge are the pre-edge ones, as the block sees them.
  // Results are checked before the beat is noted; latency keeps the two apart anyway.
  always @(posedge clk_i) begin
    beat_t seen;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) sb.check_magnitude(shear_magnitude_o);
      if (start && !busy) begin
        seen.s = {stress_zz_i, stress_zy_i, stress_zx_i,
                  stress_yz_i, stress_yy_i, stress_yx_i,
                  stress_xz_i, stress_xy_i, stress_xx_i};
        seen.n = {normal_z_i, normal_y_i, normal_x_i};
        sb.note_beat(seen);
      end
    end
  end

  // Stress: mostly full range, some small values, some extremes
  function automatic stress_t pick_stress();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3, 4:    return stress_t'($signed($urandom_range(2000)) - 1000);
      default: return stress_t'($urandom());
    endcase
  endfunction

  // Normal: plausible unit components, in-range values, or any 16-bit pattern
  function automatic normal_t pick_normal();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ($urandom_range(1)) ? N_ONE : -N_ONE;
      2:       return ($urandom_range(1)) ? N_DIAG : -N_DIAG;
      3:       return ($urandom_range(1)) ? N_HALF2 : -N_HALF2;
      4, 5, 6: return normal_t'($signed($urandom_range(2 * 16384)) - 16384);
      default: return normal_t'($urandom());
    endcase
  endfunction

  // Directed beats: field extremes, zero and oversized normals, pure shear,
  // isotropic stress, saturation and truncation of negative products
  function automatic beat_t directed_beat(int k);
    beat_t b;
    for (int i = 0; i < 9; i++) b.s[i] = stress_t'($urandom());
    b.n = {normal_t'(0), normal_t'(0), N_ONE};
    case (k)
      0: begin b.s = '0; b.n = '0; end
      1: for (int i = 0; i < 9; i++) b.s[i] = S_MAX;
      2: begin
        for (int i = 0; i < 9; i++) b.s[i] = S_MIN;
        b.n = {normal_t'(0), N_ONE, normal_t'(0)};
      end
      3: begin
        for (int i = 0; i < 9; i++) b.s[i] = (i % 4 == 0) ? S_MAX : S_MIN;
        b.n = {N_ONE, normal_t'(0), normal_t'(0)};
      end
      4: begin for (int i = 0; i < 9; i++) b.s[i] = S_MAX; b.n = '0; end
      5: begin
        b.s = '0; b.s[1] = S_MAX; b.s[3] = S_MAX;
        b.n = {normal_t'(0), normal_t'(0), -N_ONE};
      end
      6: begin
        for (int i = 0; i < 9; i++) b.s[i] = S_MIN;
        b.n = {3{normal_t'(16'sh8000)}};
      end
      7: begin
        for (int i = 0; i < 9; i++) b.s[i] = S_MAX;
        b.n = {3{normal_t'(16'sh7fff)}};
      end
      8: begin
        for (int i = 0; i < 9; i++) b.s[i] = i[0] ? S_MIN : S_MAX;
        b.n = {normal_t'(16'sh7fff), normal_t'(16'sh8000), normal_t'(16'sh7fff)};
      end
      9:  b.n = {normal_t'(0), normal_t'(8192), normal_t'(8192)};
      10: b.n = {3{N_DIAG}};
      11: begin
        b.s = '0; b.s[0] = S_MAX; b.s[4] = S_MAX; b.s[8] = S_MAX;
        b.n = {3{N_DIAG}};
      end
      12: begin
        b.s = '0; b.s[0] = S_MAX; b.s[4] = S_MIN;
        b.n = {normal_t'(0), N_HALF2, N_HALF2};
      end
      13: begin
        b.s = '0; b.s[3] = S_MAX; b.s[6] = S_MAX;
      end
      14: begin
        b.s = '0; b.s[0] = S_MAX; b.s[1] = S_MAX; b.s[3] = S_MIN; b.s[4] = S_MIN;
        b.n = {normal_t'(0), normal_t'(16'sh7fff), normal_t'(16'sh7fff)};
      end
      15: b.n = {3{-N_ONE}};
      16: begin
        b.s = '0; b.s[0] = stress_t'(-1); b.s[3] = stress_t'(1); b.s[6] = stress_t'(-1);
      end
      17: begin
        for (int i = 0; i < 9; i++) b.s[i] = S_MIN;
        b.n = {normal_t'(1), normal_t'(-1), normal_t'(1)};
      end
      18: b.n = {-N_ONE, normal_t'(0), normal_t'(0)};
      default: b.n = {normal_t'(0), -N_ONE, normal_t'(0)};
    endcase
    return b;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send_beat(beat_t b);
    start       <= 1'b1;
    stress_xx_i <= b.s[0];
    stress_xy_i <= b.s[1];
    stress_xz_i <= b.s[2];
    stress_yx_i <= b.s[3];
    stress_yy_i <= b.s[4];
    stress_yz_i <= b.s[5];
    stress_zx_i <= b.s[6];
    stress_zy_i <= b.s[7];
    stress_zz_i <= b.s[8];
    normal_x_i  <= b.n[0];
    normal_y_i  <= b.n[1];
    normal_z_i  <= b.n[2];
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Random gap before the next beat, per the current idle percentage
  task automatic sender_gap();
    int gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    beat_t b;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    stress_xx_i <= '0;
    stress_xy_i <= '0;
    stress_xz_i <= '0;
    stress_yx_i <= '0;
    stress_yy_i <= '0;
    stress_yz_i <= '0;
    stress_zx_i <= '0;
    stress_zy_i <= '0;
    stress_zz_i <= '0;
    normal_x_i  <= '0;
    normal_y_i  <= '0;
    normal_z_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three phases: light sender idling, heavy idling, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 32;
        1:       idle_pct = 87;
        default: idle_pct = 0;
      endcase
      if (phase == 0) begin
        for (int k = 0; k < 20; k++) begin
          sender_gap();
          send_beat(directed_beat(k));
        end
      end
      for (int i = 0; i < NUM_ITEMS / 3; i++) begin
        for (int j = 0; j < 9; j++) b.s[j] = pick_stress();
        for (int j = 0; j < 3; j++) b.n[j] = pick_normal();
        sender_gap();
        send_beat(b);
      end
    end
    start <= 1'b0;

    // Drain, then allow the full pipeline depth for any stray strobe
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    if (sb.faults == 0 && sb.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
